/* hdl/stl_pkg.sv */
// Shared types, character codes, keyword table and operator matchers
// for the script token lexer. No dependencies.
package stl_pkg;

	localparam int MAX_RES = 4;

	localparam logic [6:0] K_END   = 7'd0;
	localparam logic [6:0] K_FLOAT = 7'd3;
	localparam logic [6:0] K_INT   = 7'd4;
	localparam logic [6:0] K_ID    = 7'd16;
	localparam logic [6:0] K_DOT   = 7'd28;
	localparam logic [6:0] K_ERR   = 7'd74;
	localparam logic [6:0] K_NONE  = 7'd127;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_B      = 8'h62;

	typedef struct packed {
		logic [6:0]  kind;
		logic [31:0] start_offset;
		logic [15:0] length;
		logic [23:0] line;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  size;
		logic [6:0]  code;
	} kw_t;

	typedef struct packed {
		logic [2:0] len;
		logic [6:0] code;
	} match_t;

	localparam kw_t KW_TABLE [16] = '{
		'{64'("let"), 4'd3, 7'd17},      '{64'("print"), 4'd5, 7'd21},
		'{64'("if"), 4'd2, 7'd7},        '{64'("elseif"), 4'd6, 7'd8},
		'{64'("else"), 4'd4, 7'd9},      '{64'("while"), 4'd5, 7'd10},
		'{64'("for"), 4'd3, 7'd13},      '{64'("break"), 4'd5, 7'd11},
		'{64'("continue"), 4'd8, 7'd12}, '{64'("true"), 4'd4, 7'd5},
		'{64'("false"), 4'd5, 7'd5},     '{64'("or"), 4'd2, 7'd15},
		'{64'("and"), 4'd3, 7'd14},      '{64'("undef"), 4'd5, 7'd2},
		'{64'("fn"), 4'd2, 7'd18},       '{64'("return"), 4'd6, 7'd19}
	};

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [6:0] kw_code(input logic [63:0] window, input logic [3:0] size);
		logic [6:0] r;
		r = K_ID;
		for (int i = 0; i < 16; i++) begin
			if (KW_TABLE[i].size == size && KW_TABLE[i].word == window) r = KW_TABLE[i].code;
		end
		return r;
	endfunction

	function automatic logic [6:0] op_one(input logic [7:0] c);
		logic [6:0] r;
		unique case (c)
			"(": r = 7'd22;
			")": r = 7'd23;
			"[": r = 7'd24;
			"]": r = 7'd25;
			"{": r = 7'd26;
			"}": r = 7'd27;
			".": r = 7'd28;
			",": r = 7'd29;
			"^": r = 7'd30;
			"+": r = 7'd31;
			"-": r = 7'd32;
			"#": r = 7'd33;
			"!": r = 7'd34;
			"~": r = 7'd35;
			"*": r = 7'd36;
			"/": r = 7'd37;
			"%": r = 7'd38;
			"<": r = 7'd39;
			">": r = 7'd40;
			"=": r = 7'd41;
			"&": r = 7'd42;
			"|": r = 7'd43;
			"?": r = 7'd44;
			":": r = 7'd45;
			default: r = K_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] op_two(input logic [7:0] a, input logic [7:0] b);
		logic [6:0] r;
		r = K_NONE;
		if (b == "=") begin
			unique case (a)
				"^": r = 7'd46;
				"+": r = 7'd47;
				"-": r = 7'd48;
				"!": r = 7'd49;
				"=": r = 7'd50;
				"~": r = 7'd51;
				"*": r = 7'd52;
				"/": r = 7'd53;
				"%": r = 7'd54;
				"<": r = 7'd57;
				">": r = 7'd58;
				"&": r = 7'd59;
				"|": r = 7'd60;
				default: r = K_NONE;
			endcase
		end else if (a == "<" && b == "<") r = 7'd55;
		else if (a == ">" && b == ">") r = 7'd56;
		else if (a == "|" && b == "|") r = 7'd61;
		else if (a == "?" && b == "?") r = 7'd62;
		else if (a == "-" && b == ">") r = 7'd63;
		else if (a == "<" && b == "-") r = 7'd64;
		return r;
	endfunction

	function automatic logic [6:0] op_three(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [6:0] r;
		r = K_NONE;
		if (c == "=") begin
			if (a == "!" && b == "=") r = 7'd68;
			else if (a == b) begin
				unique case (a)
					"<": r = 7'd65;
					">": r = 7'd66;
					"=": r = 7'd67;
					"/": r = 7'd69;
					"|": r = 7'd70;
					"?": r = 7'd72;
					default: r = K_NONE;
				endcase
			end
		end else if (a == "|" && b == "|" && c == "|") r = 7'd71;
		return r;
	endfunction

	function automatic logic [6:0] op_four(input logic [31:0] w);
		return (w == {"=", "|", "|", "|"}) ? 7'd73 : K_NONE;
	endfunction

	// w holds the oldest character in bits 7:0
	function automatic match_t front_match(input logic [31:0] w, input logic [2:0] cnt);
		match_t m;
		logic [6:0] c4, c3, c2, c1;
		c4 = op_four(w);
		c3 = op_three(w[7:0], w[15:8], w[23:16]);
		c2 = op_two(w[7:0], w[15:8]);
		c1 = op_one(w[7:0]);
		if (cnt >= 3'd4 && c4 != K_NONE) m = '{3'd4, c4};
		else if (cnt >= 3'd3 && c3 != K_NONE) m = '{3'd3, c3};
		else if (cnt >= 3'd2 && c2 != K_NONE) m = '{3'd2, c2};
		else if (c1 != K_NONE) m = '{3'd1, c1};
		else m = '{3'd1, K_ERR};
		return m;
	endfunction

endpackage

/* hdl/stl_core.sv */
// Scanner state and one-byte step: up to four tokens per accepted word.
// Depends on stl_pkg.
module stl_core #(
	parameter int OB = 32,
	parameter int LB = 16,
	parameter int NB = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          char_in,
	input  logic                end_of_input,
	output stl_pkg::res_t       res [stl_pkg::MAX_RES],
	output logic [2:0]          res_n
);

	typedef enum logic [3:0] {
		S_IDLE, S_DOLLAR, S_LCMT, S_BCMT, S_BSTAR, S_IDENT, S_ZERO,
		S_DEC, S_HEX, S_BIN, S_DOT, S_FRAC, S_DONE
	} state_t;

	localparam logic [LB-1:0] LEN_MAX  = '1;
	localparam logic [NB-1:0] LINE_MAX = '1;

	state_t          state_q, state_d;
	logic [23:0]     pend_q, pend_d;
	logic [1:0]      pcnt_q, pcnt_d;
	logic [63:0]     kw_q, kw_d;
	logic [OB-1:0]   ts_q, ts_d;
	logic [LB-1:0]   tl_q, tl_d;
	logic [OB-1:0]   bp_q, bp_d;
	logic [NB-1:0]   line_q, line_d;
	logic            err_q, err_d;

	stl_pkg::res_t   res_v [stl_pkg::MAX_RES];
	logic [2:0]      n_v;
	stl_pkg::res_t   fl_res [3];
	logic [2:0]      fl_n;
	logic [OB-1:0]   fl_ts;
	logic [31:0]     fbv;
	logic [2:0]      fc;
	stl_pkg::match_t fm_f;
	logic [31:0]     opb;
	logic [2:0]      opc;
	logic [OB-1:0]   ots;
	stl_pkg::match_t ofm;
	logic            redo;
	logic [LB-1:0]   tl_inc, tl_inc2;
	logic [NB-1:0]   line_inc;
	logic [6:0]      id_kind;

	function automatic stl_pkg::res_t mk(input logic [6:0] k, input logic [OB-1:0] s,
			input logic [LB-1:0] l);
		stl_pkg::res_t r;
		logic [63:0] s64;
		logic [31:0] l32;
		logic [31:0] n32;
		s64 = 64'(s);
		l32 = 32'(l);
		n32 = 32'(line_q);
		r.kind = k;
		r.start_offset = s64[31:0];
		r.length = l32[15:0];
		r.line = n32[23:0];
		r.last = 1'b0;
		return r;
	endfunction

	// drain the pending operator characters, longest match first
	always_comb begin
		fbv = {8'h00, pend_q};
		fc = {1'b0, pcnt_q};
		fl_ts = ts_q;
		fl_n = 3'd0;
		fm_f = '0;
		for (int k = 0; k < 3; k++) begin
			fl_res[k] = '0;
			if (fc != 3'd0) begin
				fm_f = stl_pkg::front_match(fbv, fc);
				fl_res[k] = mk(fm_f.code, fl_ts, LB'(fm_f.len));
				fl_n = fl_n + 3'd1;
				fc = fc - fm_f.len;
				fl_ts = fl_ts + OB'(fm_f.len);
				fbv = fbv >> {fm_f.len, 3'b000};
			end
		end
	end

	assign tl_inc   = (tl_q == LEN_MAX) ? tl_q : tl_q + LB'(1);
	assign tl_inc2  = (tl_inc == LEN_MAX) ? tl_inc : tl_inc + LB'(1);
	assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + NB'(1);
	assign id_kind  = (tl_q <= LB'(8)) ? stl_pkg::kw_code(kw_q, tl_q[3:0]) : stl_pkg::K_ID;

	always_comb begin
		state_d = state_q;
		pend_d = pend_q;
		pcnt_d = pcnt_q;
		kw_d = kw_q;
		ts_d = ts_q;
		tl_d = tl_q;
		bp_d = bp_q;
		line_d = line_q;
		err_d = err_q;
		for (int i = 0; i < stl_pkg::MAX_RES; i++) res_v[i] = '0;
		n_v = 3'd0;
		redo = 1'b0;
		opb = '0;
		opc = '0;
		ots = ts_q;
		ofm = '0;
		if (end_of_input) begin
			if (state_q == S_DONE) begin
				res_v[0] = mk(err_q ? stl_pkg::K_ERR : stl_pkg::K_END, bp_q, '0);
				n_v = 3'd1;
			end else begin
				if (!err_q) begin
					unique case (state_q)
						S_IDENT: begin
							res_v[0] = mk(id_kind, ts_q, tl_q);
							n_v = 3'd1;
						end
						S_ZERO, S_DEC, S_HEX, S_BIN: begin
							res_v[0] = mk(stl_pkg::K_INT, ts_q, tl_q);
							n_v = 3'd1;
						end
						S_DOT: begin
							res_v[0] = mk(stl_pkg::K_INT, ts_q, tl_q);
							res_v[1] = mk(stl_pkg::K_DOT, bp_q - OB'(1), LB'(1));
							n_v = 3'd2;
						end
						S_FRAC: begin
							res_v[0] = mk(stl_pkg::K_FLOAT, ts_q, tl_q);
							n_v = 3'd1;
						end
						S_DOLLAR: begin
							res_v[0] = mk(stl_pkg::K_ERR, ts_q, LB'(1));
							n_v = 3'd1;
							err_d = 1'b1;
						end
						S_BCMT, S_BSTAR: begin
							res_v[0] = mk(stl_pkg::K_ERR, ts_q, '0);
							n_v = 3'd1;
							err_d = 1'b1;
						end
						S_IDLE: begin
							for (int k = 0; k < 3; k++) begin
								if (3'(k) < fl_n) res_v[k] = fl_res[k];
							end
							n_v = fl_n;
							ts_d = fl_ts;
						end
						default: ;
					endcase
				end
				if (err_q) begin
					res_v[n_v[1:0]] = mk(stl_pkg::K_ERR, bp_q, '0);
					n_v = n_v + 3'd1;
				end else if (!err_d) begin
					res_v[n_v[1:0]] = mk(stl_pkg::K_END, bp_q, '0);
					n_v = n_v + 3'd1;
				end
				pend_d = '0;
				pcnt_d = '0;
				state_d = S_DONE;
			end
		end else if (state_q != S_DONE) begin
			bp_d = bp_q + OB'(1);
			if (!err_q) begin
				unique case (state_q)
					S_DOLLAR: begin
						if (char_in == stl_pkg::CH_DOLLAR) state_d = S_LCMT;
						else if (char_in == stl_pkg::CH_STAR) state_d = S_BCMT;
						else begin
							res_v[0] = mk(stl_pkg::K_ERR, ts_q, LB'(1));
							n_v = 3'd1;
							err_d = 1'b1;
							state_d = S_IDLE;
						end
					end
					S_LCMT: begin
						if (char_in == stl_pkg::CH_NL) begin
							line_d = line_inc;
							state_d = S_IDLE;
						end
					end
					S_BCMT, S_BSTAR: begin
						if (char_in == stl_pkg::CH_NL) line_d = line_inc;
						if (state_q == S_BSTAR && char_in == stl_pkg::CH_DOLLAR) state_d = S_IDLE;
						else state_d = (char_in == stl_pkg::CH_STAR) ? S_BSTAR : S_BCMT;
					end
					S_IDENT: begin
						if (stl_pkg::is_alpha(char_in) || stl_pkg::is_digit(char_in)) begin
							tl_d = tl_inc;
							kw_d = {kw_q[55:0], char_in};
						end else begin
							res_v[0] = mk(id_kind, ts_q, tl_q);
							n_v = 3'd1;
							redo = 1'b1;
						end
					end
					S_ZERO: begin
						if (char_in == stl_pkg::CH_X) begin
							tl_d = tl_inc;
							state_d = S_HEX;
						end else if (char_in == stl_pkg::CH_B) begin
							tl_d = tl_inc;
							state_d = S_BIN;
						end else if (stl_pkg::is_digit(char_in)) begin
							tl_d = tl_inc;
							state_d = S_DEC;
						end else if (char_in == stl_pkg::CH_DOT) state_d = S_DOT;
						else begin
							res_v[0] = mk(stl_pkg::K_INT, ts_q, tl_q);
							n_v = 3'd1;
							redo = 1'b1;
						end
					end
					S_DEC: begin
						if (stl_pkg::is_digit(char_in)) tl_d = tl_inc;
						else if (char_in == stl_pkg::CH_DOT) state_d = S_DOT;
						else begin
							res_v[0] = mk(stl_pkg::K_INT, ts_q, tl_q);
							n_v = 3'd1;
							redo = 1'b1;
						end
					end
					S_HEX: begin
						if (stl_pkg::is_hex(char_in)) tl_d = tl_inc;
						else begin
							res_v[0] = mk(stl_pkg::K_INT, ts_q, tl_q);
							n_v = 3'd1;
							redo = 1'b1;
						end
					end
					S_BIN: begin
						if (char_in == stl_pkg::CH_ZERO || char_in == stl_pkg::CH_ONE) tl_d = tl_inc;
						else begin
							res_v[0] = mk(stl_pkg::K_INT, ts_q, tl_q);
							n_v = 3'd1;
							redo = 1'b1;
						end
					end
					S_DOT: begin
						if (stl_pkg::is_digit(char_in)) begin
							tl_d = tl_inc2;
							state_d = S_FRAC;
						end else begin
							res_v[0] = mk(stl_pkg::K_INT, ts_q, tl_q);
							res_v[1] = mk(stl_pkg::K_DOT, bp_q - OB'(1), LB'(1));
							n_v = 3'd2;
							redo = 1'b1;
						end
					end
					S_FRAC: begin
						if (stl_pkg::is_digit(char_in)) tl_d = tl_inc;
						else begin
							res_v[0] = mk(stl_pkg::K_FLOAT, ts_q, tl_q);
							n_v = 3'd1;
							redo = 1'b1;
						end
					end
					default: redo = 1'b1;
				endcase
				if (redo) begin
					state_d = S_IDLE;
					if (stl_pkg::op_one(char_in) != stl_pkg::K_NONE) begin
						opb = {8'h00, pend_q} | (32'(char_in) << {pcnt_q, 3'b000});
						opc = {1'b0, pcnt_q} + 3'd1;
						ots = (pcnt_q == 2'd0) ? bp_q : ts_q;
						if (opc == 3'd4) begin
							ofm = stl_pkg::front_match(opb, opc);
							res_v[n_v[1:0]] = mk(ofm.code, ots, LB'(ofm.len));
							n_v = n_v + 3'd1;
							opb = opb >> {ofm.len, 3'b000};
							opc = opc - ofm.len;
							ots = ots + OB'(ofm.len);
						end
						pend_d = opb[23:0];
						pcnt_d = opc[1:0];
						ts_d = ots;
					end else begin
						for (int k = 0; k < 3; k++) begin
							if (3'(k) < fl_n) res_v[k] = fl_res[k];
						end
						n_v = n_v + fl_n;
						ts_d = fl_ts;
						pend_d = '0;
						pcnt_d = '0;
						if (char_in == stl_pkg::CH_SPACE || char_in == stl_pkg::CH_TAB) begin
						end else if (char_in == stl_pkg::CH_NL) begin
							line_d = line_inc;
						end else begin
							ts_d = bp_q;
							tl_d = LB'(1);
							if (char_in == stl_pkg::CH_DOLLAR) state_d = S_DOLLAR;
							else if (stl_pkg::is_digit(char_in))
								state_d = (char_in == stl_pkg::CH_ZERO) ? S_ZERO : S_DEC;
							else if (stl_pkg::is_alpha(char_in)) begin
								state_d = S_IDENT;
								kw_d = 64'(char_in);
							end else begin
								res_v[n_v[1:0]] = mk(stl_pkg::K_ERR, bp_q, LB'(1));
								n_v = n_v + 3'd1;
								err_d = 1'b1;
							end
						end
					end
				end
			end
		end
		if (n_v != 3'd0) res_v[n_v[1:0] - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q <= '0;
			pcnt_q <= '0;
			kw_q <= '0;
			ts_q <= '0;
			tl_q <= '0;
			bp_q <= '0;
			line_q <= '0;
			err_q <= 1'b0;
		end else if (en) begin
			state_q <= state_d;
			pend_q <= pend_d;
			pcnt_q <= pcnt_d;
			kw_q <= kw_d;
			ts_q <= ts_d;
			tl_q <= tl_d;
			bp_q <= bp_d;
			line_q <= line_d;
			err_q <= err_d;
		end
	end

	assign res = res_v;
	assign res_n = n_v;

	assert property (@(posedge clk) disable iff (!arst_n)
		(en && end_of_input) |=> state_q == S_DONE)
		else $error("end word did not close the stream");
	assert property (@(posedge clk) disable iff (!arst_n) !$fell(err_q))
		else $error("error flag cleared without reset");
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && !end_of_input && state_q == S_DONE) |-> res_n == 3'd0)
		else $error("token produced after end of stream");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> pcnt_q == 2'd0)
		else $error("operators pending outside idle scan");

endmodule

/* hdl/stl_outq.sv */
// Token queue: takes up to four tokens per word, hands out one per cycle unless pop_stall holds it.
// Depends on stl_pkg.
module stl_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [2:0]    push_n,
	input  stl_pkg::res_t push_res [stl_pkg::MAX_RES],
	input  logic          pop_stall,
	output logic          room,
	output logic          head_valid,
	output stl_pkg::res_t head_res
);

	localparam int DEPTH = 8;
	localparam int AW = $clog2(DEPTH);

	stl_pkg::res_t  mem_q [DEPTH];
	logic [AW-1:0]  head_q, tail_q;
	logic [AW:0]    count_q;
	logic           pop;
	logic [AW:0]    add_n;

	assign pop = (count_q != '0) && !pop_stall;
	assign add_n = push ? (AW + 1)'(push_n) : '0;
	assign room = count_q <= (AW + 1)'(DEPTH - stl_pkg::MAX_RES);
	assign head_valid = count_q != '0;
	assign head_res = mem_q[head_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < stl_pkg::MAX_RES; i++) begin
			if (push && 3'(i) < push_n) mem_q[tail_q + AW'(i)] <= push_res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (pop) head_q <= head_q + AW'(1);
			tail_q <= tail_q + add_n[AW-1:0];
			count_q <= count_q + add_n - (AW + 1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= (AW + 1)'(DEPTH))
		else $error("token queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q <= (AW + 1)'(DEPTH - stl_pkg::MAX_RES))
		else $error("word taken without queue room");
	assert property (@(posedge clk) disable iff (!arst_n)
		##1 count_q == $past(count_q) + $past(add_n) - (AW + 1)'($past(pop)))
		else $error("token queue count drifted");

endmodule

/* hdl/script_token_lexer.sv */
// Script token lexer top level: byte input, token output.
// Depends on stl_pkg, stl_core and stl_outq.
//
//   channel  handshake           payload
//   source   src_valid/src_stall char_in, end_of_input
//   token    tok_valid/tok_stall kind, start_offset, length, line, last
//
// One byte is scanned per cycle while the source is not held off; each word
// yields zero to four tokens. Tokens leave one per cycle while tok_stall is
// low, from an eight-entry queue, so the source is held off while fewer
// than four entries are free. Reset clears the scanner and empties the
// queue; no clearing pass. Each word's tokens are registered in the queue.
module script_token_lexer #(
	parameter int OFFSET_BITS = 32,
	parameter int LINE_BITS = 24,
	parameter int LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_input,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [6:0]  kind,
	output logic [31:0] start_offset,
	output logic [15:0] length,
	output logic [23:0] line,
	output logic        last
);

	logic          accept;
	logic          room;
	stl_pkg::res_t step_res [stl_pkg::MAX_RES];
	logic [2:0]    step_n;
	stl_pkg::res_t head_res;

	assign src_stall = !room;
	assign accept = src_valid && room;

	stl_core #(
		.OB(OFFSET_BITS),
		.LB(LENGTH_BITS),
		.NB(LINE_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.en(accept),
		.char_in(char_in),
		.end_of_input(end_of_input),
		.res(step_res),
		.res_n(step_n)
	);

	stl_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_n(step_n),
		.push_res(step_res),
		.pop_stall(tok_stall),
		.room(room),
		.head_valid(tok_valid),
		.head_res(head_res)
	);

	assign kind = head_res.kind;
	assign start_offset = head_res.start_offset;
	assign length = head_res.length;
	assign line = head_res.line;
	assign last = head_res.last;

endmodule

/* tb/tb_script_token_lexer.sv */
// Self-checking testbench for script_token_lexer: feeds source bytes, predicts
// the token stream in a behavioral scanner and checks every token field.
// Depends on stl_pkg and the script_token_lexer RTL.
module tb_script_token_lexer;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
	} src_word_t;

	typedef enum int {
		SC_IDLE, SC_DOLLAR, SC_LCMT, SC_BCMT, SC_BSTAR, SC_IDENT, SC_ZERO,
		SC_DEC, SC_HEX, SC_BIN, SC_DOT, SC_FRAC, SC_DONE
	} scan_t;

	localparam int WATCHDOG = 3000;
	localparam string ONE_OPS = "()[]{}.,^+-#!~*/%<>=&|?:";
	localparam string OP_CHARS = "()[]{}.,^+-#!~*/%<>=&|?:";
	localparam string KW_WORDS [16] = '{"let", "print", "if", "elseif", "else", "while",
		"for", "break", "continue", "true", "false", "or", "and", "undef", "fn", "return"};
	localparam int KW_CODES [16] = '{17, 21, 7, 8, 9, 10, 13, 11, 12, 5, 5, 15, 14, 2, 18, 19};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic [7:0]  char_in = '0;
	logic        end_of_input = 1'b0;
	logic        tok_valid;
	logic        tok_stall = 1'b0;
	logic [6:0]  kind;
	logic [31:0] start_offset;
	logic [15:0] length;
	logic [23:0] line;
	logic        last;

	src_word_t       src_q[$];
	stl_pkg::res_t   tok_expect_q[$];
	stl_pkg::res_t   step_toks[$];
	int              errs = 0;
	int              idle_run = 0;
	int              toks_seen = 0;
	int              hold_left = 0;
	bit              hold_done = 0;

	// scanner state
	scan_t       sc;
	logic [7:0]  ops[$];
	logic [63:0] kwin;
	logic [31:0] tstart;
	logic [15:0] tlen;
	logic [31:0] bpos;
	logic [23:0] lcnt;
	bit          err_latched;

	script_token_lexer dut (
		.clk, .arst_n, .src_valid, .src_stall, .char_in, .end_of_input,
		.tok_valid, .tok_stall, .kind, .start_offset, .length, .line, .last
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit hexd(logic [7:0] c);
		return dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic bit no_idle();
		return toks_seen >= 8 && toks_seen < 38;
	endfunction

	// s holds n characters, oldest in the top used byte
	function automatic int op_code(logic [31:0] s, int n);
		int r;
		r = -1;
		case (n)
			1: for (int i = 0; i < ONE_OPS.len(); i++) if (ONE_OPS[i] == s[7:0]) r = 22 + i;
			2: case (s[15:0])
				"^=": r = 46; "+=": r = 47; "-=": r = 48; "!=": r = 49; "==": r = 50;
				"~=": r = 51; "*=": r = 52; "/=": r = 53; "%=": r = 54; "<<": r = 55;
				">>": r = 56; "<=": r = 57; ">=": r = 58; "&=": r = 59; "|=": r = 60;
				"||": r = 61; "??": r = 62; "->": r = 63; "<-": r = 64;
				default: r = -1;
			endcase
			3: case (s[23:0])
				"<<=": r = 65; ">>=": r = 66; "===": r = 67; "!==": r = 68; "//=": r = 69;
				"||=": r = 70; "|||": r = 71; "??=": r = 72;
				default: r = -1;
			endcase
			4: if (s == "|||=") r = 73;
			default: r = -1;
		endcase
		return r;
	endfunction

	task automatic put_tok(logic [6:0] k, logic [31:0] st, logic [15:0] ln);
		stl_pkg::res_t t;
		if (step_toks.size() >= stl_pkg::MAX_RES) return;
		t.kind = k;
		t.start_offset = st;
		t.length = ln;
		t.line = lcnt;
		t.last = 1'b0;
		step_toks.push_back(t);
	endtask

	task automatic take_front_op();
		int n, code;
		logic [31:0] s;
		n = ops.size() > 4 ? 4 : ops.size();
		code = -1;
		for (; n > 0; n--) begin
			s = '0;
			for (int i = 0; i < n; i++) s = (s << 8) | ops[i];
			code = op_code(s, n);
			if (code >= 0) break;
		end
		if (n == 0) begin
			n = 1;
			code = stl_pkg::K_ERR;
		end
		put_tok(code[6:0], tstart, n[15:0]);
		repeat (n) void'(ops.pop_front());
		tstart += n;
	endtask

	task automatic flush_ops();
		while (ops.size() > 0) take_front_op();
	endtask

	task automatic line_inc();
		if (lcnt != '1) lcnt++;
	endtask

	task automatic len_inc();
		if (tlen != '1) tlen++;
	endtask

	task automatic emit_ident();
		logic [6:0] k;
		logic [63:0] p;
		k = stl_pkg::K_ID;
		if (tlen <= 8) begin
			for (int i = 0; i < 16; i++) begin
				if (KW_WORDS[i].len() != tlen) continue;
				p = '0;
				for (int j = 0; j < KW_WORDS[i].len(); j++) p = (p << 8) | KW_WORDS[i][j];
				if (p == kwin) begin
					k = KW_CODES[i];
					break;
				end
			end
		end
		put_tok(k, tstart, tlen);
	endtask

	task automatic scan_idle(logic [7:0] c);
		if (op_code({24'd0, c}, 1) >= 0) begin
			if (ops.size() == 0) tstart = bpos;
			ops.push_back(c);
			if (ops.size() == 4) take_front_op();
			return;
		end
		flush_ops();
		if (c == stl_pkg::CH_SPACE || c == stl_pkg::CH_TAB) return;
		if (c == stl_pkg::CH_NL) begin
			line_inc();
			return;
		end
		tstart = bpos;
		tlen = 1;
		if (c == stl_pkg::CH_DOLLAR) sc = SC_DOLLAR;
		else if (dig(c)) sc = (c == stl_pkg::CH_ZERO) ? SC_ZERO : SC_DEC;
		else if (alpha(c)) begin
			sc = SC_IDENT;
			kwin = {56'd0, c};
		end else begin
			put_tok(stl_pkg::K_ERR, bpos, 1);
			err_latched = 1;
		end
	endtask

	task automatic scan_byte(logic [7:0] c);
		bit redo;
		redo = 0;
		case (sc)
			SC_DOLLAR: begin
				if (c == stl_pkg::CH_DOLLAR) sc = SC_LCMT;
				else if (c == stl_pkg::CH_STAR) sc = SC_BCMT;
				else begin
					put_tok(stl_pkg::K_ERR, tstart, 1);
					err_latched = 1;
					sc = SC_IDLE;
				end
			end
			SC_LCMT: if (c == stl_pkg::CH_NL) begin
				line_inc();
				sc = SC_IDLE;
			end
			SC_BCMT, SC_BSTAR: begin
				if (c == stl_pkg::CH_NL) line_inc();
				if (sc == SC_BSTAR && c == stl_pkg::CH_DOLLAR) sc = SC_IDLE;
				else sc = (c == stl_pkg::CH_STAR) ? SC_BSTAR : SC_BCMT;
			end
			SC_IDENT: begin
				if (alpha(c) || dig(c)) begin
					len_inc();
					kwin = (kwin << 8) | c;
				end else begin
					emit_ident();
					redo = 1;
				end
			end
			SC_ZERO: begin
				if (c == stl_pkg::CH_X) begin
					len_inc();
					sc = SC_HEX;
				end else if (c == stl_pkg::CH_B) begin
					len_inc();
					sc = SC_BIN;
				end else if (dig(c)) begin
					len_inc();
					sc = SC_DEC;
				end else if (c == stl_pkg::CH_DOT) sc = SC_DOT;
				else begin
					put_tok(stl_pkg::K_INT, tstart, tlen);
					redo = 1;
				end
			end
			SC_DEC: begin
				if (dig(c)) len_inc();
				else if (c == stl_pkg::CH_DOT) sc = SC_DOT;
				else begin
					put_tok(stl_pkg::K_INT, tstart, tlen);
					redo = 1;
				end
			end
			SC_HEX, SC_BIN: begin
				if (sc == SC_HEX ? hexd(c) : (c == stl_pkg::CH_ZERO || c == stl_pkg::CH_ONE))
					len_inc();
				else begin
					put_tok(stl_pkg::K_INT, tstart, tlen);
					redo = 1;
				end
			end
			SC_DOT: begin
				if (dig(c)) begin
					len_inc();
					len_inc();
					sc = SC_FRAC;
				end else begin
					put_tok(stl_pkg::K_INT, tstart, tlen);
					put_tok(stl_pkg::K_DOT, bpos - 1, 1);
					redo = 1;
				end
			end
			SC_FRAC: begin
				if (dig(c)) len_inc();
				else begin
					put_tok(stl_pkg::K_FLOAT, tstart, tlen);
					redo = 1;
				end
			end
			default: redo = 1;
		endcase
		if (redo) begin
			sc = SC_IDLE;
			scan_idle(c);
		end
	endtask

	task automatic scan_end();
		bit was;
		was = err_latched;
		if (!was) begin
			case (sc)
				SC_IDENT: emit_ident();
				SC_ZERO, SC_DEC, SC_HEX, SC_BIN: put_tok(stl_pkg::K_INT, tstart, tlen);
				SC_DOT: begin
					put_tok(stl_pkg::K_INT, tstart, tlen);
					put_tok(stl_pkg::K_DOT, bpos - 1, 1);
				end
				SC_FRAC: put_tok(stl_pkg::K_FLOAT, tstart, tlen);
				SC_DOLLAR: begin
					put_tok(stl_pkg::K_ERR, tstart, 1);
					err_latched = 1;
				end
				SC_BCMT, SC_BSTAR: begin
					put_tok(stl_pkg::K_ERR, tstart, 0);
					err_latched = 1;
				end
				SC_IDLE: flush_ops();
				default: ;
			endcase
		end
		if (was) put_tok(stl_pkg::K_ERR, bpos, 0);
		else if (!err_latched) put_tok(stl_pkg::K_END, bpos, 0);
		ops.delete();
		sc = SC_DONE;
	endtask

	task automatic lex_step(src_word_t w);
		step_toks.delete();
		if (w.eoi) begin
			if (sc == SC_DONE) put_tok(err_latched ? stl_pkg::K_ERR : stl_pkg::K_END, bpos, 0);
			else scan_end();
		end else if (sc != SC_DONE) begin
			if (!err_latched) scan_byte(w.ch);
			bpos++;
		end
		if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
		foreach (step_toks[i]) tok_expect_q.push_back(step_toks[i]);
	endtask

	task automatic report_mismatch(string what, longint want, longint got);
		$display("mismatch on %s at token %0d: expected %0d, got %0d", what, toks_seen, want, got);
		errs++;
	endtask

	task automatic push_byte(logic [7:0] c);
		src_word_t w;
		w.ch = c;
		w.eoi = 1'b0;
		src_q.push_back(w);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	task automatic push_end();
		src_word_t w;
		w.ch = $urandom_range(255);
		w.eoi = 1'b1;
		src_q.push_back(w);
	endtask

	function automatic logic [7:0] rand_alnum(bit letter_only);
		int r;
		r = $urandom_range(letter_only ? 51 : 61);
		if (r < 26) return "a" + r;
		if (r < 52) return "A" + r - 26;
		return "0" + r - 52;
	endfunction

	task automatic push_token();
		logic [7:0] c;
		case ($urandom_range(9))
			0: begin
				push_byte(rand_alnum(1));
				repeat ($urandom_range(5)) push_byte(rand_alnum(0));
			end
			1: push_text(KW_WORDS[$urandom_range(15)]);
			2: repeat ($urandom_range(1, 4)) push_byte("0" + $urandom_range(9));
			3: begin
				push_text("0x");
				repeat ($urandom_range(3)) push_byte(rand_alnum(0) & 8'h4F | 8'h30);
			end
			4: begin
				push_text("0b");
				repeat ($urandom_range(4)) push_byte("0" + $urandom_range(1));
			end
			5: begin
				push_byte("0" + $urandom_range(9));
				push_byte(stl_pkg::CH_DOT);
				repeat ($urandom_range(1, 3)) push_byte("0" + $urandom_range(9));
			end
			6: begin
				push_byte("0" + $urandom_range(9));
				push_byte(stl_pkg::CH_DOT);
			end
			7: repeat ($urandom_range(1, 5)) push_byte(OP_CHARS[$urandom_range(OP_CHARS.len() - 1)]);
			8: begin
				push_text("$$");
				repeat ($urandom_range(3)) begin
					c = $urandom_range(255);
					push_byte(c == stl_pkg::CH_NL ? stl_pkg::CH_SPACE : c);
				end
				push_byte(stl_pkg::CH_NL);
			end
			default: begin
				push_text("$*");
				repeat ($urandom_range(4)) begin
					c = $urandom_range(255);
					push_byte(c == stl_pkg::CH_STAR ? stl_pkg::CH_NL : c);
				end
				push_text("**$");
			end
		endcase
		case ($urandom_range(4))
			0: ;
			2: push_byte(stl_pkg::CH_TAB);
			3: push_byte(stl_pkg::CH_NL);
			default: push_byte(stl_pkg::CH_SPACE);
		endcase
	endtask

	// driver: predict on acceptance, then offer the next word
	always @(posedge clk) begin
		src_word_t w;
		if (!arst_n) begin
			src_valid <= 1'b0;
			sc = SC_IDLE;
			ops.delete();
			kwin = '0;
			tstart = '0;
			tlen = '0;
			bpos = '0;
			lcnt = '0;
			err_latched = 0;
		end else if (!src_valid || !src_stall) begin
			if (src_valid) begin
				w.ch = char_in;
				w.eoi = end_of_input;
				lex_step(w);
			end
			if (src_q.size() == 0 || (!no_idle() && $urandom_range(99) < 12)) begin
				src_valid <= 1'b0;
			end else begin
				w = src_q.pop_front();
				src_valid <= 1'b1;
				char_in <= w.ch;
				end_of_input <= w.eoi;
			end
		end
	end

	// long receiver hold, counted in cycles
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (!hold_done && toks_seen >= 40) begin
			hold_done <= 1;
			hold_left <= 80;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: check each token against the oldest prediction
	always @(posedge clk) begin
		stl_pkg::res_t e;
		if (!arst_n) begin
			tok_stall <= 1'b0;
		end else begin
			if (tok_valid && !tok_stall) begin
				if (tok_expect_q.size() == 0) begin
					report_mismatch("unexpected token kind", -1, kind);
				end else begin
					e = tok_expect_q.pop_front();
					if (kind !== e.kind) report_mismatch("kind", e.kind, kind);
					if (start_offset !== e.start_offset)
						report_mismatch("start_offset", e.start_offset, start_offset);
					if (length !== e.length) report_mismatch("length", e.length, length);
					if (line !== e.line) report_mismatch("line", e.line, line);
					if (last !== e.last) report_mismatch("last", e.last, last);
				end
				toks_seen++;
			end
			if (hold_left > 0) begin
				tok_stall <= 1'b1;
			end else begin
				tok_stall <= !no_idle() && $urandom_range(99) < 12;
			end
		end
	end

	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (tok_valid && !tok_stall)) idle_run <= 0;
		else idle_run <= idle_run + 1;
		if (idle_run >= WATCHDOG) begin
			$display("tb_script_token_lexer: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// bare prefixes, float, integer then dot, long operators, comments
		push_text("0x 0b+9.5 4.k|||=!==\n$$");
		push_byte(8'h00);
		push_text("\n$**$else");
		wait (src_q.size() == 0 && !src_valid);
		wait (tok_expect_q.size() == 0);
		while (src_q.size() < 95) push_token();
		// flush operators into an unknown byte, then repeated end words
		push_text("<<");
		push_byte(8'hFF);
		push_text("a");
		push_end();
		push_end();
		push_byte(8'h00);
		push_end();
		wait (src_q.size() == 0 && !src_valid);
		wait (tok_expect_q.size() == 0);
		repeat (20) @(posedge clk);
		if (errs == 0 && tok_expect_q.size() == 0) begin
			$display("tb_script_token_lexer: done, clean");
		end else begin
			$display("tb_script_token_lexer: done, errors");
		end
		$finish;
	end

endmodule
